FILE: rtl/met_pkg.sv
// Shared types and constants for the Mandelbrot escape-time pixel block.
// Used by the top, met_cfg and met_div in rtl/; depends on nothing else.
`default_nettype none

package met_pkg;

    // Defaults for the top-level parameters.
    localparam int FRAC_BITS_DEF = 10;
    localparam int MAX_WIDTH_DEF = 4096;

    // Field widths.
    localparam int COORD_W   = 21;           // window corner registers
    localparam int DIFF_W    = COORD_W + 1;  // corner difference and step
    localparam int QMAG_W    = COORD_W;      // magnitude of the step dividend
    localparam int DIM_W     = 13;           // frame width and height
    localparam int POS_W     = 12;           // column and row
    localparam int LIMIT_W   = 8;            // iteration counter
    localparam int PIX_W     = 24;           // linear pixel index
    localparam int COLOUR_W  = 4;            // palette index
    localparam int CFG_IDX_W = 3;
    // Point coordinate: corner plus position times step.
    localparam int C_W       = COORD_W + POS_W + 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_X_LEFT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_TOP        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_X_RIGHT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_Y_BOTTOM     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT   = 3'd6;

    // Register reset values.
    localparam logic signed [COORD_W-1:0] X_LEFT_RST   = -21'sd2048;
    localparam logic signed [COORD_W-1:0] Y_TOP_RST    = -21'sd1024;
    localparam logic signed [COORD_W-1:0] X_RIGHT_RST  = 21'sd1024;
    localparam logic signed [COORD_W-1:0] Y_BOTTOM_RST = 21'sd1024;
    localparam logic [DIM_W-1:0]          WIDTH_RST    = 13'd320;
    localparam logic [DIM_W-1:0]          HEIGHT_RST   = 13'd200;
    localparam logic [LIMIT_W-1:0]        LIMIT_RST    = 8'd64;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_left;
        logic signed [COORD_W-1:0] y_top;
        logic signed [COORD_W-1:0] x_right;
        logic signed [COORD_W-1:0] y_bottom;
        logic [DIM_W-1:0]          frame_width;
        logic [DIM_W-1:0]          frame_height;
        logic [LIMIT_W-1:0]        iteration_limit;
    } cfg_t;

    typedef struct packed {
        logic [POS_W-1:0] column;
        logic [POS_W-1:0] row;
    } in_word_t;

    typedef struct packed {
        logic [PIX_W-1:0]    pixel_index;
        logic [LIMIT_W-1:0]  escape_count;
        logic [COLOUR_W-1:0] colour;
    } out_word_t;

endpackage

`default_nettype wire

FILE: rtl/mandelbrot_escape_time_pixel_top.sv
// Mandelbrot escape-time pixel evaluator: sequencer, point set-up and z iteration.
// Depends on met_pkg, met_cfg, met_div and met_mul.
// Per pixel: S_MUL and S_CINIT set up the point, then each z step runs S_TEST and S_ACC
// through the shared multiply unit (at most iteration_limit steps), then S_DONE.
// After reset or any configuration write the next pixel first runs the two step divisions.
// One pixel is in flight: the next is accepted only after the result word is loaded.
// Reset (rst_n, asynchronous, active low) restores the register defaults; no clearing pass.
`default_nettype none

module mandelbrot_escape_time_pixel_top #(
    parameter int FRAC_BITS = met_pkg::FRAC_BITS_DEF,
    parameter int MAX_WIDTH = met_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire met_pkg::in_word_t              in_data,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output met_pkg::out_word_t                  out_data,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [met_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [met_pkg::COORD_W-1:0]    cfg_data
);

    localparam int DIFF_W = met_pkg::DIFF_W;
    localparam int DIM_W  = met_pkg::DIM_W;
    localparam int POS_W  = met_pkg::POS_W;
    localparam int LIM_W  = met_pkg::LIMIT_W;
    localparam int PIX_W  = met_pkg::PIX_W;
    localparam int CW     = met_pkg::C_W;
    localparam int ZW     = CW + 1;
    localparam int MW     = (DIFF_W > FRAC_BITS + 2) ? DIFF_W : FRAC_BITS + 2;
    localparam int PW     = 2 * MW;
    localparam logic signed [ZW-1:0] BOUND  = ZW'(2 ** (FRAC_BITS + 1));
    localparam logic signed [ZW-1:0] NBOUND = -BOUND;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIVX  = 8'b0000_0010,
        S_DIVY  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_CINIT = 8'b0001_0000,
        S_TEST  = 8'b0010_0000,
        S_ACC   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    met_pkg::cfg_t cfg;
    logic          cfg_wr;
    logic          dirty_reg;

    logic [POS_W-1:0]        col_reg;
    logic [POS_W-1:0]        row_reg;
    logic signed [DIFF_W-1:0] sx_reg;
    logic signed [DIFF_W-1:0] sy_reg;
    logic signed [CW-1:0]    cr_reg;
    logic signed [CW-1:0]    ci_reg;
    logic signed [ZW-1:0]    zr_reg;
    logic signed [ZW-1:0]    zi_reg;
    logic [LIM_W-1:0]        count_reg;
    logic [PIX_W-1:0]        pix_reg;
    logic                    out_valid_reg;
    met_pkg::out_word_t      out_data_reg;

    logic                     in_accept;
    logic                     out_load;
    logic                     keep_going;
    logic [DIM_W-1:0]         w_eff;
    logic [DIM_W-1:0]         h_eff;
    logic signed [DIFF_W-1:0] span_x;
    logic signed [DIFF_W-1:0] span_y;
    logic                     div_start;
    logic                     div_use_y;
    logic [met_pkg::QMAG_W-1:0] div_mag;
    logic                     div_neg;
    logic [DIM_W-1:0]         div_den;
    logic                     div_done;
    logic signed [DIFF_W-1:0] div_quo;

    logic signed [MW-1:0] a0, b0, a1, b1, a2, b2;
    logic signed [PW-1:0] p0, p1, p2;
    logic signed [PW-1:0] rr_sh, ii_sh, ri_sh;
    logic signed [ZW-1:0] zr_step, zi_step;

    // Configuration registers; writes are always taken.
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;

    met_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_wr),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Effective frame size: zero counts as one, width saturates at MAX_WIDTH.
    always_comb
    begin
        w_eff = cfg.frame_width;
        if (cfg.frame_width == '0)
            w_eff = DIM_W'(1);
        else if (cfg.frame_width > DIM_W'(MAX_WIDTH))
            w_eff = DIM_W'(MAX_WIDTH);
        h_eff = (cfg.frame_height == '0) ? DIM_W'(1) : cfg.frame_height;
    end

    // Step dividends and divider operand selection.
    always_comb
    begin
        span_x  = DIFF_W'(cfg.x_right) - DIFF_W'(cfg.x_left);
        span_y  = DIFF_W'(cfg.y_bottom) - DIFF_W'(cfg.y_top);
        div_neg = div_use_y ? span_y[DIFF_W-1] : span_x[DIFF_W-1];
        if (div_use_y)
            div_mag = span_y[DIFF_W-1] ? met_pkg::QMAG_W'(-span_y)
                                       : met_pkg::QMAG_W'(span_y);
        else
            div_mag = span_x[DIFF_W-1] ? met_pkg::QMAG_W'(-span_x)
                                       : met_pkg::QMAG_W'(span_x);
        div_den = div_use_y ? h_eff : w_eff;
    end

    met_div u_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (div_start),
        .dividend_mag (div_mag),
        .negative     (div_neg),
        .divisor      (div_den),
        .done         (div_done),
        .quotient     (div_quo)
    );

    met_mul #(.MW(MW)) u_mul (
        .clk (clk),
        .a0  (a0),
        .b0  (b0),
        .a1  (a1),
        .b1  (b1),
        .a2  (a2),
        .b2  (b2),
        .p0  (p0),
        .p1  (p1),
        .p2  (p2)
    );

    // Handshake terms.
    assign in_stall   = (state_reg != S_IDLE);
    assign in_accept  = in_valid && !in_stall;
    assign out_load   = (state_reg == S_DONE) && (!out_valid_reg || !out_stall);
    assign keep_going = (count_reg < cfg.iteration_limit) &&
                        (zr_reg < BOUND) && (zr_reg > NBOUND) &&
                        (zi_reg < BOUND) && (zi_reg > NBOUND);

    // One z step from the registered products.
    always_comb
    begin
        rr_sh   = p0 >>> FRAC_BITS;
        ii_sh   = p1 >>> FRAC_BITS;
        ri_sh   = p2 >>> (FRAC_BITS - 1);
        zr_step = ZW'(rr_sh) - ZW'(ii_sh) + ZW'(cr_reg);
        zi_step = ZW'(ri_sh) + ZW'(ci_reg);
    end

    // Sequencer: next state, divider start and multiplier operands.
    always_comb
    begin
        state_next = state_reg;
        div_start  = 1'b0;
        div_use_y  = 1'b0;
        a0 = '0;
        b0 = '0;
        a1 = '0;
        b1 = '0;
        a2 = '0;
        b2 = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (dirty_reg)
                    begin
                        div_start  = 1'b1;
                        state_next = S_DIVX;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_DIVX:
            begin
                if (div_done)
                begin
                    div_start  = 1'b1;
                    div_use_y  = 1'b1;
                    state_next = S_DIVY;
                end
            end
            S_DIVY:
            begin
                div_use_y = 1'b1;
                if (div_done)
                    state_next = S_MUL;
            end
            S_MUL:
            begin
                a0 = MW'($signed({1'b0, col_reg}));
                b0 = MW'(sx_reg);
                a1 = MW'($signed({1'b0, row_reg}));
                b1 = MW'(sy_reg);
                a2 = MW'($signed({1'b0, row_reg}));
                b2 = MW'($signed({1'b0, w_eff}));
                state_next = S_CINIT;
            end
            S_CINIT:
            begin
                state_next = S_TEST;
            end
            S_TEST:
            begin
                a0 = zr_reg[MW-1:0];
                b0 = zr_reg[MW-1:0];
                a1 = zi_reg[MW-1:0];
                b1 = zi_reg[MW-1:0];
                a2 = zr_reg[MW-1:0];
                b2 = zi_reg[MW-1:0];
                state_next = keep_going ? S_ACC : S_DONE;
            end
            S_ACC:
            begin
                state_next = S_TEST;
            end
            S_DONE:
            begin
                if (out_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dirty_reg     <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr)
                dirty_reg <= 1'b1;
            else if (state_reg == S_DIVY && div_done)
                dirty_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            col_reg <= in_data.column;
            row_reg <= in_data.row;
        end
        if (state_reg == S_DIVX && div_done)
            sx_reg <= div_quo;
        if (state_reg == S_DIVY && div_done)
            sy_reg <= div_quo;
        if (state_reg == S_CINIT)
        begin
            cr_reg    <= CW'(cfg.x_left) + CW'(p0);
            ci_reg    <= CW'(cfg.y_top) + CW'(p1);
            pix_reg   <= PIX_W'(p2) + PIX_W'(col_reg);
            zr_reg    <= '0;
            zi_reg    <= '0;
            count_reg <= '0;
        end
        if (state_reg == S_ACC)
        begin
            zr_reg    <= zr_step;
            zi_reg    <= zi_step;
            count_reg <= count_reg + 1'b1;
        end
        if (out_load)
        begin
            out_data_reg.pixel_index  <= pix_reg;
            out_data_reg.escape_count <= count_reg;
            out_data_reg.colour       <= count_reg[met_pkg::COLOUR_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The iteration count never passes the limit while a pixel is being tested.
    a_count_in_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TEST) |-> (count_reg <= cfg.iteration_limit))
        else $error("iteration count above limit");

    // Every z update follows an escape test.
    a_acc_after_test: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ACC) |-> $past(state_reg == S_TEST))
        else $error("z update without escape test");

    // The divider only finishes while the sequencer waits for it.
    a_div_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIVX || state_reg == S_DIVY))
        else $error("divider finished outside a step division");

    // A new result only appears from the completion state.
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result word raised outside completion");

endmodule

`default_nettype wire

FILE: rtl/met_cfg.sv
// Configuration register file for the escape-time block.
// Depends on met_pkg for the register indexes, widths and reset values.
`default_nettype none

module met_cfg (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           wr_en,
    input  wire logic [met_pkg::CFG_IDX_W-1:0]  wr_index,
    input  wire logic [met_pkg::COORD_W-1:0]    wr_data,
    output met_pkg::cfg_t                       cfg
);

    met_pkg::cfg_t cfg_reg;

    // Register writes; an index beyond the list is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.x_left          <= met_pkg::X_LEFT_RST;
            cfg_reg.y_top           <= met_pkg::Y_TOP_RST;
            cfg_reg.x_right         <= met_pkg::X_RIGHT_RST;
            cfg_reg.y_bottom        <= met_pkg::Y_BOTTOM_RST;
            cfg_reg.frame_width     <= met_pkg::WIDTH_RST;
            cfg_reg.frame_height    <= met_pkg::HEIGHT_RST;
            cfg_reg.iteration_limit <= met_pkg::LIMIT_RST;
        end
        else if (wr_en)
        begin
            case (wr_index)
                met_pkg::CFG_X_LEFT:       cfg_reg.x_left   <= wr_data;
                met_pkg::CFG_Y_TOP:        cfg_reg.y_top    <= wr_data;
                met_pkg::CFG_X_RIGHT:      cfg_reg.x_right  <= wr_data;
                met_pkg::CFG_Y_BOTTOM:     cfg_reg.y_bottom <= wr_data;
                met_pkg::CFG_FRAME_WIDTH:
                    cfg_reg.frame_width <= wr_data[met_pkg::DIM_W-1:0];
                met_pkg::CFG_FRAME_HEIGHT:
                    cfg_reg.frame_height <= wr_data[met_pkg::DIM_W-1:0];
                met_pkg::CFG_ITER_LIMIT:
                    cfg_reg.iteration_limit <= wr_data[met_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: rtl/met_div.sv
// Restoring divider, one quotient bit per cycle, for the pixel step.
// Depends on met_pkg for widths; truncates toward zero via a sign flag.
`default_nettype none

module met_div (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    input  wire logic [met_pkg::QMAG_W-1:0]          dividend_mag,
    input  wire logic                                negative,
    input  wire logic [met_pkg::DIM_W-1:0]           divisor,
    output logic                                     done,
    output logic signed [met_pkg::DIFF_W-1:0]        quotient
);

    localparam int NW  = met_pkg::QMAG_W;
    localparam int DW  = met_pkg::DIM_W;
    localparam int CNW = $clog2(NW);

    logic            busy_reg;
    logic            done_reg;
    logic [CNW-1:0]  cnt_reg;
    logic [NW-1:0]   num_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   den_reg;
    logic            neg_reg;

    logic [DW:0]     trial;
    logic            fits;
    logic [DW:0]     diff;

    // One trial subtraction per cycle.
    always_comb
    begin
        trial = {rem_reg, num_reg[NW-1]};
        diff  = trial - {1'b0, den_reg};
        fits  = (trial >= {1'b0, den_reg});
    end

    // Control: busy flag, bit counter and completion pulse.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(NW - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: the dividend shifts out as the quotient shifts in.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend_mag;
            rem_reg <= '0;
            den_reg <= divisor;
            neg_reg <= negative;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[NW-2:0], fits};
            rem_reg <= fits ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});

endmodule

`default_nettype wire

FILE: rtl/met_mul.sv
// Shared multiply unit: three signed multipliers with registered products.
// Serves the coordinate set-up and every z step; no package dependency.
`default_nettype none

module met_mul #(
    parameter int MW = 22
) (
    input  wire logic                  clk,
    input  wire logic signed [MW-1:0]  a0,
    input  wire logic signed [MW-1:0]  b0,
    input  wire logic signed [MW-1:0]  a1,
    input  wire logic signed [MW-1:0]  b1,
    input  wire logic signed [MW-1:0]  a2,
    input  wire logic signed [MW-1:0]  b2,
    output logic signed [2*MW-1:0]     p0,
    output logic signed [2*MW-1:0]     p1,
    output logic signed [2*MW-1:0]     p2
);

    logic signed [2*MW-1:0] p0_reg;
    logic signed [2*MW-1:0] p1_reg;
    logic signed [2*MW-1:0] p2_reg;

    // Products are registered every cycle; the sequencer picks them up in the next cycle.
    always_ff @(posedge clk)
    begin
        p0_reg <= a0 * b0;
        p1_reg <= a1 * b1;
        p2_reg <= a2 * b2;
    end

    assign p0 = p0_reg;
    assign p1 = p1_reg;
    assign p2 = p2_reg;

endmodule

`default_nettype wire

FILE: test/mandelbrot_escape_time_pixel_top_tb.sv
// Self-checking testbench for the Mandelbrot escape-time pixel block.
// Needs met_pkg and mandelbrot_escape_time_pixel_top from rtl/. It predicts the result
// words in place, or takes hand-worked ones from the directed table, then runs random windows and pixels.
`timescale 1ns / 100ps

module mandelbrot_escape_time_pixel_top_tb;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 3;
    localparam int N_DIR          = 44;
    localparam int N_WINDOWS      = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    // Longest pixel: 255 z steps plus the two step divisions.
    localparam int SETTLE_CYCLES  = 600;
    localparam int REPORT_MAX     = 10;

    typedef enum logic {ROW_PIXEL, ROW_REG} row_kind_t;

    // One line of the directed table: either a register write or a pixel word,
    // the latter with an optional hand-worked result.
    typedef struct packed {
        row_kind_t                     kind;
        logic [met_pkg::CFG_IDX_W-1:0] idx;
        logic [met_pkg::COORD_W-1:0]   val;
        met_pkg::in_word_t             px;
        logic                          fixed;
        met_pkg::out_word_t            want;
    } dir_row_t;

    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          in_valid  = 1'b0;
    logic                          in_stall;
    met_pkg::in_word_t             in_data   = '0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    met_pkg::out_word_t            out_data;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [met_pkg::CFG_IDX_W-1:0] cfg_index = met_pkg::CFG_X_LEFT;
    logic [met_pkg::COORD_W-1:0]   cfg_data  = '0;

    // Predictor copy of the window registers.
    met_pkg::cfg_t      win_regs;
    met_pkg::out_word_t pending_px[$];
    dir_row_t           dir_tab [N_DIR];
    int                 fault_cnt    = 0;
    int                 quiet_cycles = 0;
    int                 rx_wait      = 0;
    bit                 tx_calm      = 1'b0;
    bit                 rx_calm      = 1'b0;

    mandelbrot_escape_time_pixel_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #(CLK_HALF) clk = 1'b1;
        #(CLK_HALF) clk = 1'b0;
    end

    // Escape-time prediction for one pixel under the current window registers.
    function automatic met_pkg::out_word_t escape_pixel(input met_pkg::in_word_t px);
        longint             w;
        longint             h;
        longint             sx;
        longint             sy;
        longint             cr;
        longint             ci;
        longint             re;
        longint             im;
        longint             nxt;
        longint             bound;
        int                 n;
        met_pkg::out_word_t o;
        bound = longint'(2) <<< met_pkg::FRAC_BITS_DEF;
        w = longint'(win_regs.frame_width);
        h = longint'(win_regs.frame_height);
        if (w < 1)
            w = 1;
        if (w > met_pkg::MAX_WIDTH_DEF)
            w = met_pkg::MAX_WIDTH_DEF;
        if (h < 1)
            h = 1;
        sx = (longint'($signed(win_regs.x_right)) - longint'($signed(win_regs.x_left))) / w;
        sy = (longint'($signed(win_regs.y_bottom)) - longint'($signed(win_regs.y_top))) / h;
        cr = longint'($signed(win_regs.x_left)) + longint'(px.column) * sx;
        ci = longint'($signed(win_regs.y_top)) + longint'(px.row) * sy;
        re = 0;
        im = 0;
        n  = 0;
        // The magnitude and limit test comes before every step, so a zero limit stops at once.
        while (n < int'(win_regs.iteration_limit) && re < bound && re > -bound &&
               im < bound && im > -bound)
        begin
            nxt = ((re * re) >>> met_pkg::FRAC_BITS_DEF)
                - ((im * im) >>> met_pkg::FRAC_BITS_DEF) + cr;
            im  = ((re * im) >>> (met_pkg::FRAC_BITS_DEF - 1)) + ci;
            re  = nxt;
            n++;
        end
        o.pixel_index  = met_pkg::PIX_W'(longint'(px.row) * w + longint'(px.column));
        o.escape_count = met_pkg::LIMIT_W'(n);
        o.colour       = met_pkg::COLOUR_W'(n);
        return o;
    endfunction

    function automatic dir_row_t px_row(input int c, input int r);
        dir_row_t d;
        d           = '0;
        d.kind      = ROW_PIXEL;
        d.px.column = met_pkg::POS_W'(c);
        d.px.row    = met_pkg::POS_W'(r);
        return d;
    endfunction

    function automatic dir_row_t px_known(input int c, input int r, input int idx,
                                          input int cnt);
        dir_row_t d;
        d                   = px_row(c, r);
        d.fixed             = 1'b1;
        d.want.pixel_index  = met_pkg::PIX_W'(idx);
        d.want.escape_count = met_pkg::LIMIT_W'(cnt);
        d.want.colour       = met_pkg::COLOUR_W'(cnt);
        return d;
    endfunction

    function automatic dir_row_t reg_row(input logic [met_pkg::CFG_IDX_W-1:0] idx,
                                         input int v);
        dir_row_t d;
        d      = '0;
        d.kind = ROW_REG;
        d.idx  = idx;
        d.val  = met_pkg::COORD_W'(v);
        return d;
    endfunction

    // A random window: mostly framing the set, sometimes anywhere in the full range.
    function automatic met_pkg::cfg_t pick_window();
        met_pkg::cfg_t c;
        int            lo;
        if ($urandom_range(0, 4) == 0)
        begin
            c.x_left  = met_pkg::COORD_W'($urandom);
            c.x_right = met_pkg::COORD_W'($urandom);
        end
        else
        begin
            lo        = int'($urandom_range(0, 1700)) - 2700;
            c.x_left  = met_pkg::COORD_W'(lo);
            c.x_right = met_pkg::COORD_W'(lo + int'($urandom_range(0, 4000)));
        end
        if ($urandom_range(0, 4) == 0)
        begin
            c.y_top    = met_pkg::COORD_W'($urandom);
            c.y_bottom = met_pkg::COORD_W'($urandom);
        end
        else
        begin
            lo         = int'($urandom_range(0, 1500)) - 2200;
            c.y_top    = met_pkg::COORD_W'(lo);
            c.y_bottom = met_pkg::COORD_W'(lo + int'($urandom_range(0, 4000)));
        end
        case ($urandom_range(0, 7))
            0:       c.frame_width = '0;
            1:       c.frame_width = met_pkg::DIM_W'($urandom_range(4097, 8191));
            2:       c.frame_width = met_pkg::DIM_W'(met_pkg::MAX_WIDTH_DEF);
            3:       c.frame_width = met_pkg::DIM_W'(1);
            default: c.frame_width = met_pkg::DIM_W'($urandom_range(2, 400));
        endcase
        case ($urandom_range(0, 7))
            0:       c.frame_height = '0;
            1:       c.frame_height = met_pkg::DIM_W'($urandom_range(4097, 8191));
            2:       c.frame_height = met_pkg::DIM_W'(4096);
            3:       c.frame_height = met_pkg::DIM_W'(1);
            default: c.frame_height = met_pkg::DIM_W'($urandom_range(2, 300));
        endcase
        case ($urandom_range(0, 7))
            0:       c.iteration_limit = '0;
            1:       c.iteration_limit = '1;
            2:       c.iteration_limit = met_pkg::LIMIT_W'(1);
            3:       c.iteration_limit = met_pkg::LIMIT_W'($urandom_range(128, 254));
            default: c.iteration_limit = met_pkg::LIMIT_W'($urandom_range(2, 80));
        endcase
        return c;
    endfunction

    // Mostly pixels inside the frame, the rest anywhere in the 12-bit range.
    function automatic met_pkg::in_word_t pick_px();
        met_pkg::in_word_t p;
        int                weff;
        int                heff;
        weff = int'(win_regs.frame_width);
        heff = int'(win_regs.frame_height);
        if (weff < 1)
            weff = 1;
        if (weff > met_pkg::MAX_WIDTH_DEF)
            weff = met_pkg::MAX_WIDTH_DEF;
        if (heff < 1)
            heff = 1;
        if (heff > 4096)
            heff = 4096;
        if ($urandom_range(0, 4) == 0)
        begin
            p.column = met_pkg::POS_W'($urandom);
            p.row    = met_pkg::POS_W'($urandom);
        end
        else
        begin
            p.column = met_pkg::POS_W'($urandom_range(0, weff - 1));
            p.row    = met_pkg::POS_W'($urandom_range(0, heff - 1));
        end
        return p;
    endfunction

    // Present one pixel word and return at the edge that accepts it. Valid stays
    // high after the accept so a back-to-back word needs no second assignment.
    task automatic send_px(input met_pkg::in_word_t w);
        int gap;
        gap = tx_calm ? 0 : int'($urandom_range(0, 13));
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Stop sending and wait until every predicted word has come back.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_px.size() != 0)
            @(posedge clk);
    endtask

    // One register write; the caller lowers cfg_valid after the last of a batch.
    task automatic reg_write(input logic [met_pkg::CFG_IDX_W-1:0] idx,
                             input logic [met_pkg::COORD_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            met_pkg::CFG_X_LEFT:       win_regs.x_left       = val;
            met_pkg::CFG_Y_TOP:        win_regs.y_top        = val;
            met_pkg::CFG_X_RIGHT:      win_regs.x_right      = val;
            met_pkg::CFG_Y_BOTTOM:     win_regs.y_bottom     = val;
            met_pkg::CFG_FRAME_WIDTH:  win_regs.frame_width  = val[met_pkg::DIM_W-1:0];
            met_pkg::CFG_FRAME_HEIGHT: win_regs.frame_height = val[met_pkg::DIM_W-1:0];
            met_pkg::CFG_ITER_LIMIT:
                win_regs.iteration_limit = val[met_pkg::LIMIT_W-1:0];
            default:                   ;
        endcase
    endtask

    task automatic load_window(input met_pkg::cfg_t c);
        reg_write(met_pkg::CFG_X_LEFT, c.x_left);
        reg_write(met_pkg::CFG_Y_TOP, c.y_top);
        reg_write(met_pkg::CFG_X_RIGHT, c.x_right);
        reg_write(met_pkg::CFG_Y_BOTTOM, c.y_bottom);
        reg_write(met_pkg::CFG_FRAME_WIDTH, met_pkg::COORD_W'(c.frame_width));
        reg_write(met_pkg::CFG_FRAME_HEIGHT, met_pkg::COORD_W'(c.frame_height));
        reg_write(met_pkg::CFG_ITER_LIMIT, met_pkg::COORD_W'(c.iteration_limit));
        cfg_valid <= 1'b0;
    endtask

    // Result side: after each accepted word, hold stall for a drawn number of
    // cycles in which a word is waiting.
    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
            rx_wait = rx_calm ? 0 : int'($urandom_range(0, 13));
        else if (out_valid && rx_wait != 0)
            rx_wait = rx_wait - 1;
        out_stall <= (rx_wait != 0);
    end

    // Compare each accepted result word with the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_px.size() == 0)
            begin
                fault_cnt++;
                if (fault_cnt <= REPORT_MAX)
                    $display("%0t: unexpected word index=%0d count=%0d color=%0d", $realtime,
                             out_data.pixel_index, out_data.escape_count, out_data.colour);
            end
            else
            begin
                if (out_data.pixel_index !== pending_px[0].pixel_index ||
                    out_data.escape_count !== pending_px[0].escape_count ||
                    out_data.colour !== pending_px[0].colour)
                begin
                    fault_cnt++;
                    if (fault_cnt <= REPORT_MAX)
                        $display("%0t: mismatch index %0d/%0d count %0d/%0d color %0d/%0d",
                                 $realtime, pending_px[0].pixel_index, out_data.pixel_index,
                                 pending_px[0].escape_count, out_data.escape_count,
                                 pending_px[0].colour, out_data.colour);
                end
                void'(pending_px.pop_front());
            end
        end
    end

    // Watchdog: too long without any handshake on any channel ends the run.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("mandelbrot_escape_time_pixel_top test failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        int                k;
        int                ph;
        int                n_items;
        met_pkg::in_word_t px;
        win_regs = '{met_pkg::X_LEFT_RST, met_pkg::Y_TOP_RST, met_pkg::X_RIGHT_RST,
                     met_pkg::Y_BOTTOM_RST, met_pkg::WIDTH_RST, met_pkg::HEIGHT_RST,
                     met_pkg::LIMIT_RST};
        dir_tab = '{
            // Reset window: the corner escapes on its first step.
            px_known(0, 0, 0, 1),
            px_row(319, 199),
            px_row(160, 100),
            // Pixel outside the frame still gets evaluated.
            px_known(4095, 4095, 1314495, 1),
            // Zero limit.
            reg_row(met_pkg::CFG_ITER_LIMIT, 0),
            px_known(160, 100, 32160, 0),
            reg_row(met_pkg::CFG_ITER_LIMIT, 255),
            px_row(160, 100),
            px_row(100, 100),
            // Zero width acts as one: the step spans the whole window.
            reg_row(met_pkg::CFG_FRAME_WIDTH, 0),
            px_known(0, 5, 5, 1),
            // Oversized width clamps to the maximum, also in the index.
            reg_row(met_pkg::CFG_FRAME_WIDTH, 8191),
            px_known(4095, 4095, 16777215, 1),
            reg_row(met_pkg::CFG_FRAME_WIDTH, 4096),
            px_row(2048, 0),
            // Zero and oversized height.
            reg_row(met_pkg::CFG_FRAME_HEIGHT, 0),
            px_row(10, 0),
            px_row(10, 4095),
            reg_row(met_pkg::CFG_FRAME_HEIGHT, 8191),
            px_row(0, 4095),
            // Real part just inside and exactly at +2.0.
            reg_row(met_pkg::CFG_X_LEFT, 2047),
            reg_row(met_pkg::CFG_X_RIGHT, 2049),
            reg_row(met_pkg::CFG_FRAME_WIDTH, 2),
            px_row(0, 0),
            px_row(1, 0),
            // Imaginary part at -2.0, at +2.0 and just inside.
            reg_row(met_pkg::CFG_X_LEFT, 0),
            reg_row(met_pkg::CFG_Y_TOP, -2048),
            px_row(0, 0),
            reg_row(met_pkg::CFG_Y_TOP, 2048),
            px_row(0, 0),
            reg_row(met_pkg::CFG_Y_TOP, 2047),
            px_row(0, 0),
            // Widest window with single-pixel frame, then the reversed window.
            reg_row(met_pkg::CFG_X_LEFT, -1048576),
            reg_row(met_pkg::CFG_X_RIGHT, 1048575),
            reg_row(met_pkg::CFG_Y_TOP, -1048576),
            reg_row(met_pkg::CFG_Y_BOTTOM, 1048575),
            reg_row(met_pkg::CFG_FRAME_WIDTH, 1),
            reg_row(met_pkg::CFG_FRAME_HEIGHT, 1),
            px_row(0, 0),
            px_row(4095, 4095),
            reg_row(met_pkg::CFG_X_LEFT, 1048575),
            reg_row(met_pkg::CFG_X_RIGHT, -1048576),
            px_row(4095, 0),
            px_row(2730, 1365)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        for (k = 0; k < N_DIR; k++)
        begin
            if (dir_tab[k].kind == ROW_REG)
            begin
                drain();
                reg_write(dir_tab[k].idx, dir_tab[k].val);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_px(dir_tab[k].px);
                pending_px.push_back(dir_tab[k].fixed ? dir_tab[k].want
                                                      : escape_pixel(dir_tab[k].px));
            end
        end

        // Random windows, each followed by a burst of pixels. Slow windows get
        // fewer pixels to bound the run time.
        for (ph = 0; ph < N_WINDOWS; ph++)
        begin
            drain();
            load_window(pick_window());
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            n_items = (win_regs.iteration_limit > 128) ? 40 : 110;
            for (k = 0; k < n_items; k++)
            begin
                px = pick_px();
                send_px(px);
                pending_px.push_back(escape_pixel(px));
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fault_cnt == 0)
            $display("mandelbrot_escape_time_pixel_top test passed");
        else
            $display("mandelbrot_escape_time_pixel_top test failed");
        $finish;
    end

endmodule
